// ===== rtl/dcrp_pkg.sv =====
// shared types and constants of the rgb pwm relay node
package dcrp_pkg;

	localparam int unsigned QueueDepth = 4;

	localparam logic [15:0] PeriodTopReset = 16'd256;
	localparam logic [7:0]  RedDutyReset   = 8'd255;
	localparam logic [7:0]  IdxLength      = 8'd0;
	localparam logic [7:0]  IdxRed         = 8'd1;
	localparam logic [7:0]  IdxGreen       = 8'd2;
	localparam logic [7:0]  IdxBlue        = 8'd3;
	localparam logic [7:0]  HeaderBytes    = 8'd3;

	typedef enum logic {
		KIND_BYTE = 1'b0,
		KIND_TICK = 1'b1
	} item_kind_t;

	typedef struct packed {
		item_kind_t kind;
		logic [7:0] data;
	} q_item_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       red_on;
		logic       green_on;
		logic       blue_on;
	} result_t;

	typedef struct packed {
		logic valid;
		logic ready;
	} link_t;

endpackage

// ===== rtl/dcrp_if.sv =====
// channel interfaces of the rgb pwm relay node
interface dcrp_item_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] rx_byte;

	modport source (output valid, output opcode, output rx_byte, input ready);
	modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

interface dcrp_result_if;
	logic       valid;
	logic       ready;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic       red_on;
	logic       green_on;
	logic       blue_on;

	modport source (output valid, output tx_valid, output tx_byte, output red_on,
		output green_on, output blue_on, input ready);
	modport sink (input valid, input tx_valid, input tx_byte, input red_on,
		input green_on, input blue_on, output ready);
endinterface

// ===== rtl/daisy_chain_rgb_pwm_relay.sv =====
// top level of the daisy chained rgb led node with pwm outputs
// channels: item carries opcode (0 = serial byte, 1 = pwm tick) and rx_byte;
// result carries tx_valid, tx_byte and the red, green and blue levels.
// every item produces exactly one result, in order.
// packets: byte 0 is the length, bytes 1..3 set the duties, byte 3 sends
// length minus 3 downstream, later bytes are forwarded while below length.
// path: the input register takes the item at its transfer, then the queue,
// then the result register. throughput: one item per cycle while result
// does not stall, set by the combinational parser and pwm step.
// cfg_wr_en with cfg_wr_data loads period_top; write it only while idle.
// reset: period_top 256, red duty 255, other duties, counter and index 0;
// no items in flight.
// when result stalls, the result register holds, the queue fills, and then
// item.ready drops; nothing is lost or repeated.
module daisy_chain_rgb_pwm_relay #(
	parameter int unsigned QUEUE_DEPTH = dcrp_pkg::QueueDepth
) (
	input  logic          clk,
	input  logic          arst_n,
	dcrp_item_if.sink     item,
	dcrp_result_if.source result,
	input  logic          cfg_wr_en,
	input  logic [15:0]   cfg_wr_data
);

	logic [15:0]       period_top_q;
	dcrp_pkg::q_item_t push_item;
	dcrp_pkg::link_t   push_link;
	logic              push_ready;
	logic              pop_valid;
	dcrp_pkg::q_item_t pop_item;
	logic              pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_top_q <= dcrp_pkg::PeriodTopReset;
		end else if (cfg_wr_en) begin
			period_top_q <= cfg_wr_data;
		end
	end

	dcrp_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.item            (item),
		.push_item       (push_item),
		.push_valid_only (push_link),
		.push_ready      (push_ready)
	);

	dcrp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push_link),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop        (pop)
	);

	dcrp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.period_top (period_top_q),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop        (pop),
		.result     (result)
	);

endmodule

// ===== rtl/dcrp_front.sv =====
// front stage: accepts items, classifies them and pushes them to the queue
module dcrp_front (
	input  logic                clk,
	input  logic                arst_n,
	dcrp_item_if.sink           item,
	output dcrp_pkg::q_item_t   push_item,
	output dcrp_pkg::link_t     push_valid_only,
	input  logic                push_ready
);

	logic              valid_s1;
	dcrp_pkg::q_item_t item_s1;
	logic              take;

	assign item.ready = !valid_s1 || push_ready;
	assign take       = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.kind <= item.opcode ? dcrp_pkg::KIND_TICK : dcrp_pkg::KIND_BYTE;
			item_s1.data <= item.opcode ? 8'd0 : item.rx_byte;
		end
	end

	assign push_item             = item_s1;
	assign push_valid_only.valid = valid_s1;
	assign push_valid_only.ready = push_ready;

endmodule

// ===== rtl/dcrp_queue.sv =====
// short fifo between front and back stages
module dcrp_queue #(
	parameter int unsigned DEPTH = dcrp_pkg::QueueDepth
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dcrp_pkg::link_t   push,
	input  dcrp_pkg::q_item_t push_item,
	output logic              push_ready,
	output logic              pop_valid,
	output dcrp_pkg::q_item_t pop_item,
	input  logic              pop
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	dcrp_pkg::q_item_t entries_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = entries_q[rd_ptr_q];
	assign do_push    = push.valid && push.ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== rtl/dcrp_back.sv =====
// back stage: packet parser, pwm counter and result register
module dcrp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [15:0]       period_top,
	input  logic              pop_valid,
	input  dcrp_pkg::q_item_t pop_item,
	output logic              pop,
	dcrp_result_if.source     result
);

	logic [7:0]        byte_index_q;
	logic [7:0]        packet_length_q;
	logic [7:0]        red_duty_q;
	logic [7:0]        green_duty_q;
	logic [7:0]        blue_duty_q;
	logic [15:0]       pwm_count_q;
	logic              res_valid_q;
	dcrp_pkg::result_t res_q;

	logic [7:0]        idx_n;
	logic [7:0]        len_n;
	logic [7:0]        red_n;
	logic [7:0]        green_n;
	logic [7:0]        blue_n;
	logic [15:0]       count_n;
	logic [8:0]        idx_inc;
	dcrp_pkg::result_t res_n;

	assign pop     = pop_valid && (!res_valid_q || result.ready);
	assign idx_inc = {1'b0, byte_index_q} + 9'd1;

	always_comb begin
		idx_n          = byte_index_q;
		len_n          = packet_length_q;
		red_n          = red_duty_q;
		green_n        = green_duty_q;
		blue_n         = blue_duty_q;
		count_n        = pwm_count_q;
		res_n.tx_valid = 1'b0;
		res_n.tx_byte  = 8'd0;
		case (pop_item.kind)
			dcrp_pkg::KIND_TICK: begin
				count_n = (pwm_count_q >= period_top) ? 16'd0 : pwm_count_q + 16'd1;
			end
			dcrp_pkg::KIND_BYTE: begin
				case (byte_index_q)
					dcrp_pkg::IdxLength: len_n   = pop_item.data;
					dcrp_pkg::IdxRed:    red_n   = pop_item.data;
					dcrp_pkg::IdxGreen:  green_n = pop_item.data;
					default: begin
						if (byte_index_q == dcrp_pkg::IdxBlue) begin
							blue_n         = pop_item.data;
							res_n.tx_valid = 1'b1;
							res_n.tx_byte  = packet_length_q - dcrp_pkg::HeaderBytes;
						end else if (byte_index_q < packet_length_q) begin
							res_n.tx_valid = 1'b1;
							res_n.tx_byte  = pop_item.data;
						end
					end
				endcase
				if (byte_index_q >= dcrp_pkg::IdxBlue
						&& idx_inc >= {1'b0, packet_length_q}) begin
					idx_n = 8'd0;
				end else begin
					idx_n = idx_inc[7:0];
				end
			end
			default: ;
		endcase
		res_n.red_on   = (count_n < {8'd0, red_n});
		res_n.green_on = (count_n < {8'd0, green_n});
		res_n.blue_on  = (count_n < {8'd0, blue_n});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q    <= '0;
			packet_length_q <= '0;
			red_duty_q      <= dcrp_pkg::RedDutyReset;
			green_duty_q    <= '0;
			blue_duty_q     <= '0;
			pwm_count_q     <= '0;
			res_valid_q     <= 1'b0;
		end else begin
			if (pop) begin
				byte_index_q    <= idx_n;
				packet_length_q <= len_n;
				red_duty_q      <= red_n;
				green_duty_q    <= green_n;
				blue_duty_q     <= blue_n;
				pwm_count_q     <= count_n;
				res_valid_q     <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_n;
		end
	end

	assign result.valid    = res_valid_q;
	assign result.tx_valid = res_q.tx_valid;
	assign result.tx_byte  = res_q.tx_byte;
	assign result.red_on   = res_q.red_on;
	assign result.green_on = res_q.green_on;
	assign result.blue_on  = res_q.blue_on;

endmodule
